// ----- rtl/core/kmcd_pkg.sv -----
// Shared types and constants for the key matrix change detector.
package kmcd_pkg;

    localparam int COL_W     = 3;
    localparam int ROW_W     = 16;
    localparam int ROW_IDX_W = 4;
    localparam int CODE_W    = 7;

    localparam logic [ROW_W-1:0] SNAPSHOT_RESET = 16'hdfff;

    // One column scan that has at least one changed row, handed to the event sequencer.
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] sample;
        logic [ROW_W-1:0] changed;
    } scan_job_t;

endpackage

// ----- rtl/core/kmcd_front.sv -----
// Scan intake: enable register, column snapshots and change classification.
module kmcd_front #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS    = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         scan_enable,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kmcd_pkg::COL_W-1:0]   column_index,
    input  logic [kmcd_pkg::ROW_W-1:0]   row_lines,
    output logic                         job_valid,
    input  logic                         job_ready,
    output kmcd_pkg::scan_job_t          job
);
    import kmcd_pkg::*;

    localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int CMP_W = COL_W + 2;
    localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((32'd1 << NUM_ROWS) - 32'd1);

    logic             enable_reg;
    logic [ROW_W-1:0] snapshot_reg [NUM_COLUMNS];
    logic [CMP_W-1:0] col_wide;
    logic             in_range;
    logic [IDX_W-1:0] col_idx;
    logic [ROW_W-1:0] stored;
    logic [ROW_W-1:0] changed;
    logic             take;

    assign cfg_ready = 1'b1;
    assign in_ready  = job_ready;

    assign col_wide = CMP_W'(column_index);
    assign in_range = (col_wide < CMP_W'(NUM_COLUMNS));
    assign col_idx  = col_wide[IDX_W-1:0];
    assign stored   = snapshot_reg[col_idx];
    assign changed  = (row_lines ^ stored) & ROW_MASK;
    assign take     = in_valid && in_ready && enable_reg && in_range;

    // Only scans that change something go on to the sequencer.
    assign job_valid      = take && (changed != '0);
    assign job.column     = column_index;
    assign job.sample     = row_lines;
    assign job.changed    = changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            enable_reg <= scan_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COLUMNS; i++)
            begin
                snapshot_reg[i] <= SNAPSHOT_RESET;
            end
        end
        else if (take)
        begin
            snapshot_reg[col_idx] <= row_lines;
        end
    end

endmodule

// ----- rtl/core/kmcd_queue.sv -----
// Two-entry job queue between scan intake and event sequencer.
module kmcd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  kmcd_pkg::scan_job_t push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output kmcd_pkg::scan_job_t pop_job
);
    import kmcd_pkg::*;

    scan_job_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

// ----- rtl/core/kmcd_back.sv -----
// Event sequencer: walks the changed rows of one scan, one key event per cycle while the receiver accepts them.
module kmcd_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_ready,
    input  kmcd_pkg::scan_job_t          job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [kmcd_pkg::CODE_W-1:0]  key_code,
    output logic                         pressed,
    output logic                         last_event
);
    import kmcd_pkg::*;

    logic [ROW_W-1:0]     mask_reg;
    logic [ROW_W-1:0]     mask_next;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     sample_reg;
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    key_code_reg;
    logic                 pressed_reg;
    logic                 last_reg;
    logic [ROW_IDX_W-1:0] low_row;
    logic [ROW_W-1:0]     rest;
    logic                 load;
    logic                 emit;

    assign job_ready = (mask_reg == '0);
    assign load      = job_valid && job_ready;
    assign emit      = (mask_reg != '0) && (!out_valid_reg || out_ready);

    // Lowest pending row goes first.
    always_comb
    begin
        low_row = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_row = ROW_IDX_W'(i);
            end
        end
    end

    // Drop the lowest set bit.
    assign rest = mask_reg & (mask_reg - ROW_W'(1));

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = job.changed;
        end
        else if (emit)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg    <= job.column;
            sample_reg <= job.sample;
        end
        if (emit)
        begin
            key_code_reg <= {low_row, col_reg};
            pressed_reg  <= ~sample_reg[low_row];
            last_reg     <= (rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_code   = key_code_reg;
    assign pressed    = pressed_reg;
    assign last_event = last_reg;

    a_job_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (mask_reg != '0))
        else $error("sequencer loaded a scan with no changed rows");

    a_one_row_per_event: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> ($countones(mask_reg) == $countones($past(mask_reg)) - 1))
        else $error("event did not retire exactly one row");

    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && (last_reg == (mask_reg == '0))))
        else $error("last-event flag disagrees with pending rows");

endmodule

// ----- rtl/core/key_matrix_change_detector_unit.sv -----
// Key matrix change detector: top level joining scan intake, job queue and event sequencer.
//
// Input channel (in_valid/in_ready): one transfer per column scan, carrying the
// driven column and the 16 active-low row lines. Config channel (cfg_valid/
// cfg_ready, always ready) writes scan_enable; write it only while the block is idle.
// Output channel (out_valid/out_ready): one transfer per changed row, in ascending
// row order, with key_code = row*8+column, pressed when the line went low, and
// last_event on the final event of the scan.
// A scan with k changed rows occupies the sequencer for a load of the job from the
// queue, once the previous scan is done, and then one event per changed row.
// With the sequencer idle, a scan passes through the queue entry, the sequencer's
// row mask and the output registers before its first event is valid.
// Scans are taken one per cycle while the two-entry queue has room; disabled,
// out-of-range or unchanged scans never enter the queue, but they too wait while
// it is full.
// A stalled receiver holds the current event and, once the queue fills, in_ready.
// Reset clears scan_enable, empties the queue and sets every column snapshot to
// 0xdfff.
module key_matrix_change_detector_unit #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS    = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         scan_enable,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [kmcd_pkg::COL_W-1:0]   column_index,
    input  logic [kmcd_pkg::ROW_W-1:0]   row_lines,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [kmcd_pkg::CODE_W-1:0]  key_code,
    output logic                         pressed,
    output logic                         last_event
);
    import kmcd_pkg::*;

    logic      push_valid;
    logic      push_ready;
    scan_job_t push_job;
    logic      pop_valid;
    logic      pop_ready;
    scan_job_t pop_job;

    kmcd_front #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .scan_enable  (scan_enable),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .column_index (column_index),
        .row_lines    (row_lines),
        .job_valid    (push_valid),
        .job_ready    (push_ready),
        .job          (push_job)
    );

    kmcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    kmcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job        (pop_job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_code   (key_code),
        .pressed    (pressed),
        .last_event (last_event)
    );

endmodule
